FILE: rtl/core/dssrs_pkg.sv
// ----------------------------------------------------------------------------
// dssrs_pkg
// Shared types and constants for the dynamic SPAD selection and range scaling
// pipeline.
// ----------------------------------------------------------------------------
package dssrs_pkg;

    // field widths
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned RATE_W     = 32;
    localparam int unsigned RANGE_PROD_W = 27;
    localparam int unsigned RANGE_SHIFT  = 11;

    // division step counts
    localparam int unsigned RATE_STEPS = 32;
    localparam int unsigned SPAD_STEPS = 16;

    // constants of the range scaling
    localparam logic [10:0] RANGE_SCALE = 11'd2011;
    localparam logic [10:0] RANGE_ROUND = 11'h400;
    localparam logic [15:0] SCALED_RANGE_MAX = 16'd64351;

    // register reset and clip value
    localparam logic [15:0] TARGET_RATE_RESET = 16'h0A00;
    localparam logic [15:0] CLIP16 = 16'hFFFF;

    // side information that travels with an item through both dividers
    typedef struct packed {
        logic        spad_zero;
        logic        calibrate_request;
        logic [15:0] scaled_range;
    } tag_t;

    // one finished result item
    typedef struct packed {
        logic [15:0] required_spads;
        logic        spads_valid;
        logic [15:0] scaled_range;
        logic        calibrate_request;
    } out_item_t;

endpackage

FILE: rtl/core/dssrs_if.sv
// ----------------------------------------------------------------------------
// dssrs channel interfaces
// Valid/ready channels for result blocks, result items and the target rate
// register write.
// ----------------------------------------------------------------------------

// input channel: one time-of-flight result block per transfer
interface dssrs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] spad_count;
    logic [15:0] ambient_rate;
    logic [15:0] peak_signal_rate;
    logic [15:0] raw_range;

    modport source (
        output valid, spad_count, ambient_rate, peak_signal_rate, raw_range,
        input  ready
    );
    modport sink (
        input  valid, spad_count, ambient_rate, peak_signal_rate, raw_range,
        output ready
    );
endinterface

// output channel: one result item per transfer
interface dssrs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] required_spads;
    logic        spads_valid;
    logic [15:0] scaled_range;
    logic        calibrate_request;

    modport source (
        output valid, required_spads, spads_valid, scaled_range, calibrate_request,
        input  ready
    );
    modport sink (
        input  valid, required_spads, spads_valid, scaled_range, calibrate_request,
        output ready
    );
endinterface

// configuration channel: write data of the target rate register
interface dssrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

FILE: rtl/core/dssrs_rate_div.sv
// ----------------------------------------------------------------------------
// dssrs_rate_div
// Pipelined restoring divider: per_spad = (sum << 16) / spad_count, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module dssrs_rate_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [15:0]         sum,
    input  logic [15:0]         spad_count,
    input  dssrs_pkg::tag_t     in_tag,
    output logic                out_valid,
    output logic [31:0]         per_spad,
    output dssrs_pkg::tag_t     out_tag
);

    localparam int unsigned STEPS = dssrs_pkg::RATE_STEPS;

    // stage registers
    logic                valid_reg [STEPS];
    logic [15:0]         rem_reg   [STEPS];
    logic [31:0]         dq_reg    [STEPS];
    logic [15:0]         div_reg   [STEPS];
    dssrs_pkg::tag_t     tag_reg   [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic                src_valid;
        logic [15:0]         src_rem;
        logic [31:0]         src_dq;
        logic [15:0]         src_div;
        dssrs_pkg::tag_t     src_tag;
        logic [16:0]         trial;
        logic                fits;
        logic [15:0]         rem_next;
        logic [31:0]         dq_next;

        // stage source: the block inputs or the previous stage
        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = '0;
            assign src_dq    = {sum, 16'h0000};
            assign src_div   = spad_count;
            assign src_tag   = in_tag;
        end else begin : g_rest
            assign src_valid = valid_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_dq    = dq_reg[k-1];
            assign src_div   = div_reg[k-1];
            assign src_tag   = tag_reg[k-1];
        end

        // one restoring step: the dividend bit shifts out, the quotient bit in
        assign trial    = {src_rem, src_dq[31]};
        assign fits     = (trial >= {1'b0, src_div});
        assign rem_next = fits ? 16'(trial - {1'b0, src_div}) : trial[15:0];
        assign dq_next  = {src_dq[30:0], fits};

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= src_valid;
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                dq_reg[k]  <= dq_next;
                div_reg[k] <= src_div;
                tag_reg[k] <= src_tag;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign per_spad  = dq_reg[STEPS-1];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

FILE: rtl/core/dssrs_spad_div.sv
// ----------------------------------------------------------------------------
// dssrs_spad_div
// Pipelined divider for the SPAD request: (target_rate << 16) / per_spad,
// clipped to 16 bits, plus assembly of the result item.
// ----------------------------------------------------------------------------
module dssrs_spad_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [31:0]           per_spad,
    input  logic [15:0]           target_rate,
    input  dssrs_pkg::tag_t       in_tag,
    output logic                  out_valid,
    output dssrs_pkg::out_item_t  out_item
);

    localparam int unsigned STEPS = dssrs_pkg::SPAD_STEPS;

    // entry stage: saturation and zero checks, remainder seeded with target
    logic                entry_valid_reg;
    logic [31:0]         entry_rem_reg;
    logic [31:0]         entry_div_reg;
    logic                entry_sat_reg;
    logic                entry_zero_reg;
    dssrs_pkg::tag_t     entry_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= in_valid;
        end
    end

    // quotient exceeds 16 bits exactly when per_spad <= target_rate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_rem_reg  <= 32'(target_rate);
            entry_div_reg  <= per_spad;
            entry_sat_reg  <= (per_spad <= 32'(target_rate));
            entry_zero_reg <= (per_spad == 32'h0);
            entry_tag_reg  <= in_tag;
        end
    end

    // step stage registers
    logic                valid_reg [STEPS];
    logic [31:0]         rem_reg   [STEPS];
    logic [15:0]         quo_reg   [STEPS];
    logic [31:0]         div_reg   [STEPS];
    logic                sat_reg   [STEPS];
    logic                zero_reg  [STEPS];
    dssrs_pkg::tag_t     tag_reg   [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic                src_valid;
        logic [31:0]         src_rem;
        logic [15:0]         src_quo;
        logic [31:0]         src_div;
        logic                src_sat;
        logic                src_zero;
        dssrs_pkg::tag_t     src_tag;
        logic [32:0]         trial;
        logic                fits;
        logic [31:0]         rem_next;
        logic [15:0]         quo_next;

        // stage source: the entry stage or the previous step
        if (k == 0) begin : g_first
            assign src_valid = entry_valid_reg;
            assign src_rem   = entry_rem_reg;
            assign src_quo   = '0;
            assign src_div   = entry_div_reg;
            assign src_sat   = entry_sat_reg;
            assign src_zero  = entry_zero_reg;
            assign src_tag   = entry_tag_reg;
        end else begin : g_rest
            assign src_valid = valid_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_quo   = quo_reg[k-1];
            assign src_div   = div_reg[k-1];
            assign src_sat   = sat_reg[k-1];
            assign src_zero  = zero_reg[k-1];
            assign src_tag   = tag_reg[k-1];
        end

        // one restoring step, low dividend bits are all zero
        assign trial    = {src_rem, 1'b0};
        assign fits     = (trial >= {1'b0, src_div});
        assign rem_next = fits ? 32'(trial - {1'b0, src_div}) : trial[31:0];
        assign quo_next = {src_quo[14:0], fits};

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= src_valid;
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                div_reg[k]  <= src_div;
                sat_reg[k]  <= src_sat;
                zero_reg[k] <= src_zero;
                tag_reg[k]  <= src_tag;
            end
        end
    end

    // result assembly from the last step
    logic spads_ok;

    assign spads_ok = !tag_reg[STEPS-1].spad_zero && !zero_reg[STEPS-1];

    always_comb
    begin
        out_item.spads_valid       = spads_ok;
        out_item.scaled_range      = tag_reg[STEPS-1].scaled_range;
        out_item.calibrate_request = tag_reg[STEPS-1].calibrate_request;
        if (!spads_ok)
        begin
            out_item.required_spads = '0;
        end
        else if (sat_reg[STEPS-1])
        begin
            out_item.required_spads = dssrs_pkg::CLIP16;
        end
        else
        begin
            out_item.required_spads = quo_reg[STEPS-1];
        end
    end

    assign out_valid = valid_reg[STEPS-1];

endmodule

FILE: rtl/core/dynamic_spad_select_and_range_scale_top.sv
// ----------------------------------------------------------------------------
// dynamic_spad_select_and_range_scale_top
// Per result block: SPAD request from the summed return rate and range scaled
// by 2011/2048, with a one-time calibration request after reset.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  item      in    valid/ready    spad_count, ambient_rate, peak_signal_rate,
//                                 raw_range
//  result    out   valid/ready    required_spads, spads_valid, scaled_range,
//                                 calibrate_request
//  cfg       in    valid/ready    data (target_rate), ready always high
//
//  One item per cycle while the skid register is free; the path from transfer in
//  to result valid runs through the input stage, 32 steps of the rate divider,
//  entry plus 16 steps of the SPAD divider, one quotient bit per stage.
//  rst_n clears all valid bits and the calibration flag and sets target_rate to 0x0A00.
//  A one-entry skid register behind the last stage takes a stalled result;
//  while it is full the whole pipeline holds and item.ready is low.
//
module dynamic_spad_select_and_range_scale_top (
    input  logic        clk,
    input  logic        rst_n,
    dssrs_in_if.sink    item,
    dssrs_out_if.source result,
    dssrs_cfg_if.sink   cfg
);

    logic                  en;
    logic                  accept;
    logic                  calibration_done_reg;
    logic [15:0]           target_rate_reg;

    logic                  s0_valid_reg;
    logic [15:0]           s0_sum_reg;
    logic [15:0]           s0_spad_reg;
    dssrs_pkg::tag_t       s0_tag_reg;

    logic [16:0]           sum_wide;
    logic [15:0]           sum_sat;
    logic [26:0]           range_prod;

    logic                  rate_valid;
    logic [31:0]           rate_per_spad;
    dssrs_pkg::tag_t       rate_tag;

    logic                  last_valid;
    dssrs_pkg::out_item_t  last_item;

    logic                  skid_full_reg;
    dssrs_pkg::out_item_t  skid_reg;
    dssrs_pkg::out_item_t  out_item;

    // pipeline advances whenever the skid register is free
    assign en          = !skid_full_reg;
    assign item.ready  = en;
    assign accept      = item.valid && en;

    // target rate register write
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_rate_reg <= dssrs_pkg::TARGET_RATE_RESET;
        end
        else if (cfg.valid)
        begin
            target_rate_reg <= cfg.data;
        end
    end

    // first transfer after reset carries the calibration request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibration_done_reg <= 1'b0;
        end
        else if (accept)
        begin
            calibration_done_reg <= 1'b1;
        end
    end

    // rate sum with clipping and range scaling
    assign sum_wide   = 17'(item.ambient_rate) + 17'(item.peak_signal_rate);
    assign sum_sat    = sum_wide[16] ? dssrs_pkg::CLIP16 : sum_wide[15:0];
    assign range_prod = 27'(item.raw_range) * 27'(dssrs_pkg::RANGE_SCALE)
                      + 27'(dssrs_pkg::RANGE_ROUND);

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_sum_reg                   <= sum_sat;
            s0_spad_reg                  <= item.spad_count;
            s0_tag_reg.spad_zero         <= (item.spad_count == 16'h0);
            s0_tag_reg.calibrate_request <= !calibration_done_reg;
            s0_tag_reg.scaled_range      <= range_prod[26:dssrs_pkg::RANGE_SHIFT];
        end
    end

    // per-SPAD rate divider
    dssrs_rate_div u_rate_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s0_valid_reg),
        .sum        (s0_sum_reg),
        .spad_count (s0_spad_reg),
        .in_tag     (s0_tag_reg),
        .out_valid  (rate_valid),
        .per_spad   (rate_per_spad),
        .out_tag    (rate_tag)
    );

    // SPAD request divider
    dssrs_spad_div u_spad_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (rate_valid),
        .per_spad    (rate_per_spad),
        .target_rate (target_rate_reg),
        .in_tag      (rate_tag),
        .out_valid   (last_valid),
        .out_item    (last_item)
    );

    // skid register for a stalled result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (en && last_valid && !result.ready)
        begin
            skid_full_reg <= 1'b1;
        end
        else if (skid_full_reg && result.ready)
        begin
            skid_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && last_valid && !result.ready)
        begin
            skid_reg <= last_item;
        end
    end

    // output select
    assign out_item                 = skid_full_reg ? skid_reg : last_item;
    assign result.valid             = skid_full_reg || last_valid;
    assign result.required_spads    = out_item.required_spads;
    assign result.spads_valid       = out_item.spads_valid;
    assign result.scaled_range      = out_item.scaled_range;
    assign result.calibrate_request = out_item.calibrate_request;

endmodule

FILE: rtl/core/dssrs_checker.sv
// ----------------------------------------------------------------------------
// dssrs_checker
// Port-level checks on the result channel of the SPAD selection block, bound
// to the top level.
// ----------------------------------------------------------------------------
module dssrs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [15:0] required_spads,
    input  logic        spads_valid,
    input  logic [15:0] scaled_range,
    input  logic        calibrate_request
);

    logic result_xfer;
    logic first_seen_reg;

    assign result_xfer = result_valid && result_ready;

    // tracks whether any result has been transferred since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seen_reg <= 1'b0;
        end
        else if (result_xfer)
        begin
            first_seen_reg <= 1'b1;
        end
    end

    // a stalled result holds
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(required_spads) && $stable(spads_valid)
            && $stable(scaled_range) && $stable(calibrate_request)
    ) else $error("result changed while stalled");

    // calibration request on the first result only
    a_calib_once: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_xfer |-> (calibrate_request == !first_seen_reg)
    ) else $error("calibration request not on first result alone");

    // an invalid SPAD request carries zero
    a_spads_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !spads_valid |-> (required_spads == 16'h0)
    ) else $error("required_spads nonzero while not valid");

    // scaled range stays in its range
    a_range_max: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (scaled_range <= dssrs_pkg::SCALED_RANGE_MAX)
    ) else $error("scaled_range above scaled maximum");

endmodule

bind dynamic_spad_select_and_range_scale_top dssrs_checker u_dssrs_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .required_spads    (result.required_spads),
    .spads_valid       (result.spads_valid),
    .scaled_range      (result.scaled_range),
    .calibrate_request (result.calibrate_request)
);

FILE: sim/tb_dynamic_spad_select_and_range_scale_top.sv
// ----------------------------------------------------------------------------
// tb_dynamic_spad_select_and_range_scale_top
// Drives time-of-flight result blocks into the SPAD selection and range
// scaling pipeline and checks every result item against a local prediction or
// a hand-written result. A directed set of boundary blocks runs first. Random
// blocks follow under several target rates, with random gaps on both channels
// and one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dynamic_spad_select_and_range_scale_top;

    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned PHASE_BLOCKS = 160;
    localparam int unsigned HOLD_CYCLES  = 240;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned NUM_DIRECTED = 12;
    localparam int unsigned TIMEOUT_NS   = 4_000_000;

    // one result block as it enters the pipeline
    typedef struct packed {
        logic [15:0] spad_count;
        logic [15:0] ambient_rate;
        logic [15:0] peak_signal_rate;
        logic [15:0] raw_range;
    } tof_block_t;

    // directed row: block plus an optional hand-written result
    typedef struct packed {
        tof_block_t           blk;
        logic                 typed;
        dssrs_pkg::out_item_t res;
    } directed_row_t;

    logic clk;
    logic rst_n;

    dssrs_in_if  item_if ();
    dssrs_out_if res_if ();
    dssrs_cfg_if cfg_if ();

    dynamic_spad_select_and_range_scale_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if.sink),
        .result (res_if.source),
        .cfg    (cfg_if.sink)
    );

    // shadow state of the block
    logic [15:0] shadow_target;
    logic        shadow_calib_done;

    dssrs_pkg::out_item_t pending_results[$];
    int unsigned          mismatch_count;

    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    logic        hold_go;
    logic        rx_hold;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted result of one block, advances the calibration flag
    function automatic dssrs_pkg::out_item_t spad_range_predict(input tof_block_t b);
        dssrs_pkg::out_item_t r;
        logic [16:0]          rate_sum;
        logic [15:0]          rate_clip;
        logic [31:0]          per_spad;
        logic [31:0]          spad_quo;
        logic [31:0]          range_prod;
        r = '0;
        r.calibrate_request = !shadow_calib_done;
        shadow_calib_done = 1'b1;
        rate_sum = {1'b0, b.ambient_rate} + {1'b0, b.peak_signal_rate};
        rate_clip = rate_sum[16] ? dssrs_pkg::CLIP16 : rate_sum[15:0];
        if (b.spad_count != 16'd0)
        begin
            per_spad = {rate_clip, 16'h0000} / {16'h0000, b.spad_count};
            if (per_spad != 32'd0)
            begin
                spad_quo = {shadow_target, 16'h0000} / per_spad;
                r.required_spads = (spad_quo > {16'h0000, dssrs_pkg::CLIP16})
                                   ? dssrs_pkg::CLIP16 : spad_quo[15:0];
                r.spads_valid = 1'b1;
            end
        end
        range_prod = {16'h0000, b.raw_range} * {21'd0, dssrs_pkg::RANGE_SCALE}
                     + {21'd0, dssrs_pkg::RANGE_ROUND};
        r.scaled_range = range_prod[dssrs_pkg::RANGE_SHIFT +: 16];
        return r;
    endfunction

    // random block, weighted toward the corners of the rate arithmetic
    function automatic tof_block_t random_block();
        tof_block_t  b;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)
            b.spad_count = 16'd0;
        else if (pick < 30)
            b.spad_count = 16'($urandom_range(16, 1));
        else if (pick < 40)
            b.spad_count = 16'(65535 - $urandom_range(15));
        else
            b.spad_count = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            b.ambient_rate = 16'd0;
            b.peak_signal_rate = 16'd0;
        end
        else if (pick < 20)
        begin
            b.ambient_rate = 16'($urandom_range(15));
            b.peak_signal_rate = 16'($urandom_range(15));
        end
        else if (pick < 35)
        begin
            b.ambient_rate = 16'($urandom_range(65535, 32768));
            b.peak_signal_rate = 16'($urandom_range(65535, 32768));
        end
        else
        begin
            b.ambient_rate = 16'($urandom);
            b.peak_signal_rate = 16'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 3)
            b.raw_range = 16'd0;
        else if (pick < 6)
            b.raw_range = dssrs_pkg::CLIP16;
        else
            b.raw_range = 16'($urandom);
        return b;
    endfunction

    // offer one block with random gaps, record its result on transfer
    task automatic send_block(input tof_block_t b, input logic typed,
                              input dssrs_pkg::out_item_t res);
        dssrs_pkg::out_item_t pred;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.spad_count <= b.spad_count;
        item_if.ambient_rate <= b.ambient_rate;
        item_if.peak_signal_rate <= b.peak_signal_rate;
        item_if.raw_range <= b.raw_range;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        pred = spad_range_predict(b);
        pending_results.push_back(typed ? res : pred);
        @(negedge clk);
    endtask

    // register write, called at a falling edge
    task automatic write_target(input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        shadow_target = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // wait until every expected result has come back
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // result side ready, with random stalls and the long hold-off
    initial
    begin : result_ready_drive
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
                res_if.ready <= 1'b0;
            else
                res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin : receiver_hold
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        rx_hold = 1'b0;
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result spads=%0d valid=%0d range=%0d calib=%0d",
                         $time, res_if.required_spads, res_if.spads_valid,
                         res_if.scaled_range, res_if.calibrate_request);
            end
            else
            begin
                automatic dssrs_pkg::out_item_t want = pending_results.pop_front();
                if (res_if.required_spads !== want.required_spads)
                begin
                    mismatch_count++;
                    $display("%0t: required_spads expected %0d actual %0d",
                             $time, want.required_spads, res_if.required_spads);
                end
                if (res_if.spads_valid !== want.spads_valid)
                begin
                    mismatch_count++;
                    $display("%0t: spads_valid expected %0d actual %0d",
                             $time, want.spads_valid, res_if.spads_valid);
                end
                if (res_if.scaled_range !== want.scaled_range)
                begin
                    mismatch_count++;
                    $display("%0t: scaled_range expected %0d actual %0d",
                             $time, want.scaled_range, res_if.scaled_range);
                end
                if (res_if.calibrate_request !== want.calibrate_request)
                begin
                    mismatch_count++;
                    $display("%0t: calibrate_request expected %0d actual %0d",
                             $time, want.calibrate_request, res_if.calibrate_request);
                end
            end
        end
    end

    // run limit
    initial
    begin : run_limit
        #(TIMEOUT_NS);
        $display("[dynamic_spad_select_and_range_scale_top] ERROR");
        $finish;
    end

    // stimulus sequence
    initial
    begin : stimulus
        directed_row_t directed_rows[NUM_DIRECTED];
        logic [15:0]   phase_target[NUM_PHASES];
        directed_rows = '{
            // first block after reset, no spads: calibration request only
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
              '{16'd0, 1'b0, 16'd0, 1'b1}},
            // no spads, top of every field: largest range
            '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
              '{16'd0, 1'b0, dssrs_pkg::SCALED_RANGE_MAX, 1'b0}},
            // zero rate: per-spad rate is zero, no request
            '{'{16'h0001, 16'h0000, 16'h0000, 16'h0001}, 1'b1,
              '{16'd0, 1'b0, 16'd1, 1'b0}},
            // clipped rate over all spads: request equals target
            '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1,
              '{dssrs_pkg::TARGET_RATE_RESET, 1'b1, 16'd0, 1'b0}},
            // tiny per-spad rate: request saturates
            '{'{16'hFFFF, 16'h0000, 16'h0001, 16'h0000}, 1'b1,
              '{dssrs_pkg::CLIP16, 1'b1, 16'd0, 1'b0}},
            '{'{16'h0001, 16'hFFFF, 16'h0000, 16'd1024}, 1'b0, '0},
            '{'{16'h0001, 16'h8000, 16'h8000, 16'd2048}, 1'b0, '0},
            '{'{16'h8000, 16'h0001, 16'h0000, 16'h5555}, 1'b0, '0},
            '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA}, 1'b0, '0},
            '{'{16'h5555, 16'hAAAA, 16'h5555, 16'h5555}, 1'b0, '0},
            '{'{16'h0002, 16'h0100, 16'h0200, 16'd1000}, 1'b0, '0},
            '{'{16'h00FF, 16'h1234, 16'h0042, 16'h7FFF}, 1'b0, '0}
        };
        phase_target = '{dssrs_pkg::CLIP16, 16'h0000, 16'($urandom), 16'h0001,
                         16'($urandom), dssrs_pkg::TARGET_RATE_RESET};

        // known levels and reset
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.spad_count = '0;
        item_if.ambient_rate = '0;
        item_if.peak_signal_rate = '0;
        item_if.raw_range = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        hold_go = 1'b0;
        snd_idle_pct = 21;
        rcv_idle_pct = 73;
        mismatch_count = 0;
        shadow_target = dssrs_pkg::TARGET_RATE_RESET;
        shadow_calib_done = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed blocks at the reset target rate
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_block(directed_rows[i].blk, directed_rows[i].typed, directed_rows[i].res);
        item_if.valid <= 1'b0;
        drain_results();

        // random phases, one target rate each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            @(posedge clk);
            if (p < 2)
            begin
                snd_idle_pct = 21;
                rcv_idle_pct = 73;
            end
            else if (p < 4)
            begin
                snd_idle_pct = 73;
                rcv_idle_pct = 21;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            @(negedge clk);
            write_target(phase_target[p]);
            if (p == 4)
                hold_go = 1'b1;
            for (int n = 0; n < PHASE_BLOCKS; n++)
                send_block(random_block(), 1'b0, '0);
            item_if.valid <= 1'b0;
            drain_results();
        end

        // let any stray result show up
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("[dynamic_spad_select_and_range_scale_top] OK");
        else
            $display("[dynamic_spad_select_and_range_scale_top] ERROR");
        $finish;
    end

endmodule
